>>> hdl/fvn_pkg.sv
// shared constants and register codes for the fractal value noise block
package fvn_pkg;

	// binary point of the frequency and of the fraction
	localparam int FRAC_BITS = 24;

	// hash mixing constants
	localparam logic [63:0] HASH_K1    = 64'hbf58476d1ce4e5b9;
	localparam logic [31:0] HASH_K2_LO = 32'h133111eb;

	// smoothstep weight width, it can reach five times one
	localparam int U_W  = FRAC_BITS + 3;
	// first blend level, signed
	localparam int A_W  = 37;
	// magnitude of the second blend difference and its split point
	localparam int E_W  = 37;
	localparam int E_LO = 19;
	// octave noise value, signed
	localparam int N_W  = 42;

	// configuration register indexes
	localparam int          CFG_IDX_W   = 1;
	localparam logic [0:0]  REG_SCALE   = 1'b0;
	localparam logic [0:0]  REG_OCTAVES = 1'b1;

	// register reset values
	localparam logic [31:0] SCALE_RESET   = 32'd167772;
	localparam logic [3:0]  OCTAVES_RESET = 4'd4;

	// saturation bounds of the result
	localparam logic [31:0] OUT_POS_MAX = 32'h7fffffff;
	localparam logic [31:0] OUT_NEG_MIN = 32'h80000000;

endpackage

>>> hdl/fvn_octave.sv
// one octave lane: coordinate split, corner hashes, smoothstep and bilinear blend
module fvn_octave #(
	parameter int OCT = 0
) (
	input  logic                             clk,
	input  logic                             en,
	input  logic [63:0]                      px,
	input  logic [63:0]                      pz,
	input  logic                             sx,
	input  logic                             sz,
	output logic signed [fvn_pkg::N_W-1:0]   n
);

	localparam int F    = fvn_pkg::FRAC_BITS;
	localparam int U_W  = fvn_pkg::U_W;
	localparam int A_W  = fvn_pkg::A_W;
	localparam int E_W  = fvn_pkg::E_W;
	localparam int E_LO = fvn_pkg::E_LO;
	localparam int N_W  = fvn_pkg::N_W;

	// stage 1: frequency shift and split into integer and fraction
	logic [79:0]             wx, wz;
	logic [31:0]             ipx, ipz;
	logic [F-1:0]            frx, frz;
	logic [31:0]             ix_s1, iz_s1;
	logic signed [F:0]       fx_s1, fz_s1;

	assign wx  = {16'b0, px} << OCT;
	assign wz  = {16'b0, pz} << OCT;
	assign ipx = wx[F+31:F];
	assign ipz = wz[F+31:F];
	assign frx = wx[F-1:0];
	assign frz = wz[F-1:0];

	always_ff @(posedge clk) begin
		if (en) begin
			ix_s1 <= sx ? (32'd0 - ipx) : ipx;
			iz_s1 <= sz ? (32'd0 - ipz) : ipz;
			fx_s1 <= sx ? -$signed({1'b0, frx}) : $signed({1'b0, frx});
			fz_s1 <= sz ? -$signed({1'b0, frz}) : $signed({1'b0, frz});
		end
	end

	// stage 2: hash seed per corner, squared fraction magnitude
	logic [63:0]       h_s2 [4];
	logic [2*F-1:0]    sqx_s2, sqz_s2;
	logic signed [F:0] fx_s2, fz_s2;
	logic [F-1:0]      fmx, fmz;
	logic signed [F:0] fnx, fnz;

	assign fnx = -fx_s1;
	assign fnz = -fz_s1;
	assign fmx = fx_s1[F] ? fnx[F-1:0] : fx_s1[F-1:0];
	assign fmz = fz_s1[F] ? fnz[F-1:0] : fz_s1[F-1:0];

	always_ff @(posedge clk) begin
		if (en) begin
			sqx_s2 <= fmx * fmx;
			sqz_s2 <= fmz * fmz;
			fx_s2  <= fx_s1;
			fz_s2  <= fz_s1;
		end
	end

	// stage 3 and up per corner: multiply rounds of the hash
	logic [63:0] p00_s3 [4];
	logic [31:0] p01_s3 [4];
	logic [31:0] p10_s3 [4];
	logic [31:0] hb_s4  [4];
	logic [31:0] cv_s5  [4];

	for (genvar k = 0; k < 4; k++) begin : g_corner
		logic [31:0] ca, cb;
		logic [63:0] sa, sb, h0, h1v;

		assign ca  = (k % 2 == 1) ? (ix_s1 + 32'd1) : ix_s1;
		assign cb  = (k / 2 == 1) ? (iz_s1 + 32'd1) : iz_s1;
		assign sa  = {{32{ca[31]}}, ca};
		assign sb  = {{32{cb[31]}}, cb};
		assign h0  = (sa << 5) - sa + sb;
		assign h1v = p00_s3[k] + {p01_s3[k] + p10_s3[k], 32'b0};

		always_ff @(posedge clk) begin
			if (en) begin
				h_s2[k]   <= h0 ^ (h0 >> 30);
				p00_s3[k] <= h_s2[k][31:0] * fvn_pkg::HASH_K1[31:0];
				p01_s3[k] <= h_s2[k][31:0] * fvn_pkg::HASH_K1[63:32];
				p10_s3[k] <= h_s2[k][63:32] * fvn_pkg::HASH_K1[31:0];
				hb_s4[k]  <= h1v[31:0] ^ h1v[58:27];
				cv_s5[k]  <= hb_s4[k] * fvn_pkg::HASH_K2_LO;
			end
		end
	end

	// smoothstep: f2 * (3 - 2f)
	logic signed [F+2:0] tvx, tvz;
	logic [2*F+2:0]      tpx_s3, tpz_s3;
	logic [U_W-1:0]      ux_s4, uz_s4, ux_s5, uz_s5, ux_s6, uz_s6, uz_s7, uz_s8, uz_s9;

	assign tvx = $signed((F+3)'(3) << F) - ($signed({{2{fx_s2[F]}}, fx_s2}) <<< 1);
	assign tvz = $signed((F+3)'(3) << F) - ($signed({{2{fz_s2[F]}}, fz_s2}) <<< 1);

	always_ff @(posedge clk) begin
		if (en) begin
			tpx_s3 <= sqx_s2[2*F-1:F] * $unsigned(tvx);
			tpz_s3 <= sqz_s2[2*F-1:F] * $unsigned(tvz);
			ux_s4  <= tpx_s3[2*F+2:F];
			uz_s4  <= tpz_s3[2*F+2:F];
			ux_s5  <= ux_s4;
			uz_s5  <= uz_s4;
			ux_s6  <= ux_s5;
			uz_s6  <= uz_s5;
			uz_s7  <= uz_s6;
			uz_s8  <= uz_s7;
			uz_s9  <= uz_s8;
		end
	end

	// stage 6: corner differences along x as sign and magnitude
	logic [32:0] d1, d2, d1n, d2n;
	logic [31:0] d1mag_s6, d2mag_s6, v1_s6, v3_s6, v1_s7, v3_s7;
	logic        d1neg_s6, d2neg_s6, d1neg_s7, d2neg_s7;

	assign d1  = {1'b0, cv_s5[1]} - {1'b0, cv_s5[0]};
	assign d2  = {1'b0, cv_s5[3]} - {1'b0, cv_s5[2]};
	assign d1n = 33'd0 - d1;
	assign d2n = 33'd0 - d2;

	always_ff @(posedge clk) begin
		if (en) begin
			d1neg_s6 <= d1[32];
			d2neg_s6 <= d2[32];
			d1mag_s6 <= d1[32] ? d1n[31:0] : d1[31:0];
			d2mag_s6 <= d2[32] ? d2n[31:0] : d2[31:0];
			v1_s6    <= cv_s5[0];
			v3_s6    <= cv_s5[2];
		end
	end

	// stage 7: weight the x differences
	logic [U_W+31:0] q1_s7, q2_s7;

	always_ff @(posedge clk) begin
		if (en) begin
			q1_s7    <= ux_s6 * d1mag_s6;
			q2_s7    <= ux_s6 * d2mag_s6;
			d1neg_s7 <= d1neg_s6;
			d2neg_s7 <= d2neg_s6;
			v1_s7    <= v1_s6;
			v3_s7    <= v3_s6;
		end
	end

	// stage 8: blend along x, truncated toward zero
	logic signed [A_W-1:0] t1, t2, a_s8, b_s8;

	assign t1 = $signed(A_W'(q1_s7[U_W+31:F]));
	assign t2 = $signed(A_W'(q2_s7[U_W+31:F]));

	always_ff @(posedge clk) begin
		if (en) begin
			a_s8 <= $signed(A_W'(v1_s7)) + (d1neg_s7 ? -t1 : t1);
			b_s8 <= $signed(A_W'(v3_s7)) + (d2neg_s7 ? -t2 : t2);
		end
	end

	// stage 9: difference along z as sign and magnitude
	logic signed [A_W:0]   e, en_v;
	logic [E_W-1:0]        emag_s9;
	logic                  eneg_s9, eneg_s10, eneg_s11;
	logic signed [A_W-1:0] a_s9, a_s10, a_s11;

	assign e    = $signed({b_s8[A_W-1], b_s8}) - $signed({a_s8[A_W-1], a_s8});
	assign en_v = -e;

	always_ff @(posedge clk) begin
		if (en) begin
			eneg_s9 <= e[A_W];
			emag_s9 <= e[A_W] ? en_v[E_W-1:0] : e[E_W-1:0];
			a_s9    <= a_s8;
		end
	end

	// stages 10 and 11: weight the z difference in two partial products
	logic [U_W+E_LO-1:0]     rlo_s10;
	logic [U_W+E_W-E_LO-1:0] rhi_s10;
	logic [U_W+E_W-1:0]      r_s11;

	always_ff @(posedge clk) begin
		if (en) begin
			rlo_s10  <= uz_s9 * emag_s9[E_LO-1:0];
			rhi_s10  <= uz_s9 * emag_s9[E_W-1:E_LO];
			eneg_s10 <= eneg_s9;
			a_s10    <= a_s9;
			r_s11    <= (U_W+E_W)'(rlo_s10) + ((U_W+E_W)'(rhi_s10) << E_LO);
			eneg_s11 <= eneg_s10;
			a_s11    <= a_s10;
		end
	end

	// stage 12: final blend of this octave
	logic signed [N_W-1:0] rs, n_s12;

	assign rs = $signed(N_W'(r_s11[U_W+E_W-1:F]));

	always_ff @(posedge clk) begin
		if (en) begin
			n_s12 <= $signed({{(N_W-A_W){a_s11[A_W-1]}}, a_s11}) + (eneg_s11 ? -rs : rs);
		end
	end

	assign n = n_s12;

endmodule

>>> hdl/fractal_value_noise_2d_top.sv
// Fractal value noise over a 2D integer coordinate: one sample enters per clock while the
// pipeline is not held. Each sample passes through two input stages, twelve stages in each
// octave lane, three stages of weighted summing, one 8-bit restoring divide step per stage
// for the mean, and the output register. All octave lanes run side by side, so the rate does
// not depend on octave_count. When the output request is not taken the whole pipeline holds.
// Configuration writes are meant for idle periods only.
module fractal_value_noise_2d_top #(
	parameter int MAX_OCTAVES = 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// config write port
	input  logic                            cfg_we,
	input  logic [fvn_pkg::CFG_IDX_W-1:0]   cfg_addr,
	input  logic [31:0]                     cfg_wdata,
	// input stream
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [63:0]                     s_tdata,   // x_coord[31:0], z_coord[63:32]
	// output stream
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [39:0]                     m_tdata    // noise_value[31:0], was_saturated[32]
);

	localparam int N_W   = fvn_pkg::N_W;
	localparam int ACC_W = N_W + MAX_OCTAVES;
	localparam int ND    = (ACC_W + 7) / 8;
	localparam int DQ_W  = ND * 8;
	localparam int DIV_W = MAX_OCTAVES;
	localparam int NG    = (MAX_OCTAVES + 3) / 4;
	localparam int MW    = $clog2(MAX_OCTAVES + 1);
	localparam int LAT   = 18 + ND;

	// configuration registers
	logic [31:0] scale_q;
	logic [3:0]  octs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= fvn_pkg::SCALE_RESET;
			octs_q  <= fvn_pkg::OCTAVES_RESET;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				fvn_pkg::REG_SCALE:   scale_q <= cfg_wdata;
				fvn_pkg::REG_OCTAVES: octs_q  <= cfg_wdata[3:0];
				default:              scale_q <= scale_q;
			endcase
		end
	end

	// effective octave count and divisor 2^m - 1
	logic [MW-1:0]    m_w;
	logic [DIV_W-1:0] dvs;

	always_comb begin
		if (octs_q == 4'd0) begin
			m_w = MW'(1);
		end else if (int'(octs_q) > MAX_OCTAVES) begin
			m_w = MW'(MAX_OCTAVES);
		end else begin
			m_w = MW'(octs_q);
		end
		dvs = ~({DIV_W{1'b1}} << m_w);
	end

	// pipeline advance and valid chain
	logic           en;
	logic [LAT-1:0] vld_q;

	assign en       = !vld_q[LAT-1] || m_tready;
	assign s_tready = en;
	assign m_tvalid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], s_tvalid};
		end
	end

	// stage 1: coordinate magnitudes and signs
	logic [31:0] xin, zin, magx_s1, magz_s1;
	logic        sx_s1, sz_s1, sx_s2, sz_s2;
	logic [63:0] px_s2, pz_s2;

	assign xin = s_tdata[31:0];
	assign zin = s_tdata[63:32];

	always_ff @(posedge clk) begin
		if (en) begin
			magx_s1 <= xin[31] ? (32'd0 - xin) : xin;
			magz_s1 <= zin[31] ? (32'd0 - zin) : zin;
			sx_s1   <= xin[31];
			sz_s1   <= zin[31];
			// stage 2: scale by the base frequency
			px_s2   <= magx_s1 * scale_q;
			pz_s2   <= magz_s1 * scale_q;
			sx_s2   <= sx_s1;
			sz_s2   <= sz_s1;
		end
	end

	// octave lanes
	logic signed [N_W-1:0] lane_n [MAX_OCTAVES];

	for (genvar i = 0; i < MAX_OCTAVES; i++) begin : g_lane
		fvn_octave #(
			.OCT (i)
		) u_oct (
			.clk (clk),
			.en  (en),
			.px  (px_s2),
			.pz  (pz_s2),
			.sx  (sx_s2),
			.sz  (sz_s2),
			.n   (lane_n[i])
		);
	end

	// stage 15: amplitude weighting and group sums; stage 16: total of the registered group sums
	logic signed [ACC_W-1:0] term [MAX_OCTAVES];
	logic signed [ACC_W-1:0] grp_c [NG];
	logic signed [ACC_W-1:0] grp_s15 [NG];
	logic signed [ACC_W-1:0] acc_c, acc_s16;

	always_comb begin
		for (int i = 0; i < MAX_OCTAVES; i++) begin
			if (m_w > MW'(i)) begin
				term[i] = $signed({{(ACC_W-N_W){lane_n[i][N_W-1]}}, lane_n[i]})
					<<< (m_w - MW'(1) - MW'(i));
			end else begin
				term[i] = '0;
			end
		end
		for (int g = 0; g < NG; g++) begin
			grp_c[g] = '0;
			for (int j = 0; j < 4; j++) begin
				if (4 * g + j < MAX_OCTAVES) begin
					grp_c[g] = grp_c[g] + term[4*g+j];
				end
			end
		end
		acc_c = '0;
		for (int g = 0; g < NG; g++) begin
			acc_c = acc_c + grp_s15[g];
		end
	end

	// stages 15 to 17: group sums, total, sign and magnitude
	logic [ACC_W-1:0] acc_neg_v, mag_s17;
	logic             neg_s17;

	assign acc_neg_v = -acc_s16;

	always_ff @(posedge clk) begin
		if (en) begin
			grp_s15 <= grp_c;
			acc_s16 <= acc_c;
			neg_s17 <= acc_s16[ACC_W-1];
			mag_s17 <= acc_s16[ACC_W-1] ? acc_neg_v : acc_s16;
		end
	end

	// divide by 2^m - 1, eight quotient bits per stage, msb first
	logic [DQ_W-1:0]  dq_s  [ND+1];
	logic [DIV_W-1:0] dr_s  [ND+1];
	logic             dn_s  [ND+1];

	assign dq_s[0] = DQ_W'(mag_s17);
	assign dr_s[0] = '0;
	assign dn_s[0] = neg_s17;

	for (genvar k = 0; k < ND; k++) begin : g_div
		logic [DQ_W-1:0]  q_c;
		logic [DIV_W-1:0] r_c;
		logic [DIV_W:0]   r2;

		always_comb begin
			q_c = dq_s[k];
			r_c = dr_s[k];
			r2  = '0;
			for (int b = 0; b < 8; b++) begin
				r2 = {r_c, dq_s[k][DQ_W-1-8*k-b]};
				if (r2 >= {1'b0, dvs}) begin
					r2 = r2 - {1'b0, dvs};
					q_c[DQ_W-1-8*k-b] = 1'b1;
				end else begin
					q_c[DQ_W-1-8*k-b] = 1'b0;
				end
				r_c = r2[DIV_W-1:0];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dq_s[k+1] <= q_c;
				dr_s[k+1] <= r_c;
				dn_s[k+1] <= dn_s[k];
			end
		end
	end

	// output stage: scale by 2^31 - 1 over 2^32, apply sign and saturate
	logic [DQ_W+30:0] prod;
	logic [DQ_W-2:0]  mm;
	logic [31:0]      mm_neg;
	logic             sat_c;
	logic [31:0]      noise_q;
	logic             sat_q;

	assign prod   = {dq_s[ND], 31'b0} - (DQ_W+31)'(dq_s[ND]);
	assign mm     = prod[DQ_W+30:32];
	assign mm_neg = 32'd0 - mm[31:0];
	assign sat_c  = dn_s[ND] ? (mm > (DQ_W-1)'(33'h080000000))
	                         : (mm > (DQ_W-1)'(33'h07fffffff));

	always_ff @(posedge clk) begin
		if (en) begin
			sat_q <= sat_c;
			if (sat_c) begin
				noise_q <= dn_s[ND] ? fvn_pkg::OUT_NEG_MIN : fvn_pkg::OUT_POS_MAX;
			end else begin
				noise_q <= dn_s[ND] ? mm_neg : mm[31:0];
			end
		end
	end

	assign m_tdata = {7'b0, sat_q, noise_q};

endmodule
